// File: hdl/cpfs_pkg.sv
// Package for the periodic CAN frame scheduler.
// Holds sizes, request and result layouts, and the request codes.
// No dependencies.
package cpfs_pkg;

  // Sizes and timing.
  localparam int unsigned NUM_SLOTS   = 16;
  localparam int unsigned TICK_MS     = 5;
  localparam int unsigned PERIOD_BITS = 16;

  localparam int unsigned IDX_W  = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TICK_W = $clog2(TICK_MS + 1);
  localparam int unsigned SUM_W  = ((PERIOD_BITS > TICK_W) ? PERIOD_BITS : TICK_W) + 1;

  // Request kinds.
  typedef enum logic [2:0] {
    KIND_LOAD     = 3'd0,
    KIND_START    = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_QUERY    = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_SHUTDOWN = 3'd5
  } kind_t;

  // Result kinds.
  localparam logic RES_FRAME  = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  // Operating mode.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SENDING = 2'd1,
    MODE_DEAD    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot_index;
    logic [31:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [15:0] period_ms;
    logic        cyclic_flag;
    logic [3:0]  frame_count;
  } request_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] tx_id;
    logic [3:0]  tx_length;
    logic [63:0] tx_payload;
    logic        is_sending;
    logic        last;
  } result_t;

  // One stored frame slot.
  typedef struct packed {
    logic [31:0]            ident;
    logic [3:0]             len;
    logic [63:0]            bytes;
    logic [PERIOD_BITS-1:0] period;
    logic                   cyclic;
  } slot_t;

endpackage

// File: hdl/can_periodic_frame_scheduler_unit.sv
// Top level of the periodic CAN frame scheduler.
// Depends on cpfs_pkg for sizes, request and result layouts.
//
//  Channel  Ports                        Direction  Handshake
//  request  start, busy, in_request      in         taken when start and not busy
//  result   out_valid, out_result        out        one-cycle strobe, no back-pressure
//
// Load, stop, shutdown and query are handled without a slot walk; a query result appears on the next cycle.
// Start and tick walk the slots in use through one compare-subtract unit: each slot passes
// through fetch and evaluate states and, on a tick of an active cyclic slot, a modulo state that
// subtracts the period from elapsed + TICK_MS until the sum is below the period; a done state
// then closes the walk, and busy stays high until it has closed.
// Reset is synchronous and active low; it clears mode, slot count and counter valid bits.
// The receiver cannot stall; each result is offered for exactly one cycle.
module can_periodic_frame_scheduler_unit
  import cpfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  request_t in_request,
  output logic     out_valid,
  output result_t  out_result
);

  typedef enum logic [2:0] {
    ST_READY,
    ST_FETCH,
    ST_EVAL,
    ST_MOD,
    ST_DONE
  } state_t;

  state_t                 state_r;
  mode_t                  mode_r;
  logic                   op_tick_r;
  logic [CNT_W-1:0]       slots_used_r;
  logic [CNT_W-1:0]       idx_r;
  logic [NUM_SLOTS-1:0]   el_vld_r;
  logic [SUM_W-1:0]       sum_r;
  logic                   have_pend_r;
  slot_t                  pend_r;
  logic                   out_valid_r;
  result_t                out_result_r;

  // Slot and counter memories with registered read data.
  slot_t                  slot_mem [NUM_SLOTS];
  logic [PERIOD_BITS-1:0] el_mem [NUM_SLOTS];
  slot_t                  rd_slot_r;
  logic [PERIOD_BITS-1:0] rd_el_r;
  logic                   rd_el_ok_r;

  logic                   accept;
  logic                   sub_ge;
  logic                   mod_done;
  logic                   hit;
  logic                   advance;
  logic [CNT_W-1:0]       idx_inc;
  logic [CNT_W-1:0]       count_sat;
  logic [PERIOD_BITS-1:0] el_eff;
  logic [IDX_W-1:0]       rd_addr;
  slot_t                  load_slot;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_READY);
  assign rd_addr = idx_r[IDX_W-1:0];
  assign idx_inc = idx_r + CNT_W'(1);

  // Frame count saturates at the number of slots.
  assign count_sat = (32'(in_request.frame_count) > NUM_SLOTS) ?
                     CNT_W'(NUM_SLOTS) : CNT_W'(in_request.frame_count);

  // Counters not written since the last start read as zero.
  assign el_eff = rd_el_ok_r ? rd_el_r : '0;

  // Shared compare-subtract unit: reduces the sum modulo the slot period.
  assign sub_ge   = (sum_r >= SUM_W'(rd_slot_r.period));
  assign mod_done = (state_r == ST_MOD) && !sub_ge;

  // A frame is due on a punctual slot at start, or when a counter wraps to zero.
  always_comb begin
    hit     = 1'b0;
    advance = 1'b0;
    if (state_r == ST_EVAL) begin
      if (!op_tick_r) begin
        hit     = !rd_slot_r.cyclic;
        advance = 1'b1;
      end else if (!rd_slot_r.cyclic || (rd_slot_r.period == '0)) begin
        advance = 1'b1;
      end
    end else if (mod_done) begin
      hit     = (sum_r == '0);
      advance = 1'b1;
    end
  end

  assign load_slot.ident  = in_request.frame_id;
  assign load_slot.len    = in_request.frame_length;
  assign load_slot.bytes  = in_request.frame_payload;
  assign load_slot.period = PERIOD_BITS'(in_request.period_ms);
  assign load_slot.cyclic = in_request.cyclic_flag;

  // Slot memory: written by load requests while idle, read at the walk index.
  always_ff @(posedge clk) begin
    if (accept && (in_request.kind == KIND_LOAD) && (mode_r == MODE_IDLE) &&
        (32'(in_request.slot_index) < NUM_SLOTS)) begin
      slot_mem[IDX_W'(in_request.slot_index)] <= load_slot;
    end
    rd_slot_r <= slot_mem[rd_addr];
  end

  // Elapsed counter memory: written when a modulo reduction finishes.
  always_ff @(posedge clk) begin
    if (mod_done) begin
      el_mem[rd_addr] <= sum_r[PERIOD_BITS-1:0];
    end
    rd_el_r    <= el_mem[rd_addr];
    rd_el_ok_r <= el_vld_r[rd_addr];
  end

  // Sequencer, mode and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_READY;
      mode_r       <= MODE_IDLE;
      op_tick_r    <= 1'b0;
      slots_used_r <= '0;
      idx_r        <= '0;
      el_vld_r     <= '0;
      have_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_READY: begin
          if (accept) begin
            case (in_request.kind)
              KIND_START: begin
                if (mode_r == MODE_IDLE) begin
                  mode_r       <= MODE_SENDING;
                  slots_used_r <= count_sat;
                  el_vld_r     <= '0;
                  op_tick_r    <= 1'b0;
                  idx_r        <= '0;
                  if (count_sat != '0) begin
                    state_r <= ST_FETCH;
                  end
                end
              end
              KIND_STOP: begin
                if (mode_r == MODE_SENDING) begin
                  mode_r <= MODE_IDLE;
                end
              end
              KIND_QUERY: begin
                if (mode_r != MODE_DEAD) begin
                  out_valid_r             <= 1'b1;
                  out_result_r            <= '0;
                  out_result_r.result_kind <= RES_REPORT;
                  out_result_r.is_sending <= (mode_r == MODE_SENDING);
                  out_result_r.last       <= 1'b1;
                end
              end
              KIND_TICK: begin
                if ((mode_r == MODE_SENDING) && (slots_used_r != '0)) begin
                  op_tick_r <= 1'b1;
                  idx_r     <= '0;
                  state_r   <= ST_FETCH;
                end
              end
              KIND_SHUTDOWN: begin
                if (mode_r != MODE_DEAD) begin
                  mode_r <= MODE_DEAD;
                end
              end
              default: begin
                // Loads are handled by the slot memory; unknown kinds are ignored.
              end
            endcase
          end
        end
        ST_FETCH: begin
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (op_tick_r && rd_slot_r.cyclic && (rd_slot_r.period != '0)) begin
            sum_r   <= SUM_W'(el_eff) + SUM_W'(TICK_MS);
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (sub_ge) begin
            sum_r <= sum_r - SUM_W'(rd_slot_r.period);
          end else begin
            el_vld_r[rd_addr] <= 1'b1;
          end
        end
        ST_DONE: begin
          if (have_pend_r) begin
            out_valid_r              <= 1'b1;
            out_result_r.result_kind <= RES_FRAME;
            out_result_r.tx_id       <= pend_r.ident;
            out_result_r.tx_length   <= pend_r.len;
            out_result_r.tx_payload  <= pend_r.bytes;
            out_result_r.is_sending  <= 1'b0;
            out_result_r.last        <= 1'b1;
          end
          have_pend_r <= 1'b0;
          state_r     <= ST_READY;
        end
        default: begin
          state_r <= ST_READY;
        end
      endcase

      // The previous due frame goes out once a later one is found; the newest waits.
      if (hit) begin
        if (have_pend_r) begin
          out_valid_r              <= 1'b1;
          out_result_r.result_kind <= RES_FRAME;
          out_result_r.tx_id       <= pend_r.ident;
          out_result_r.tx_length   <= pend_r.len;
          out_result_r.tx_payload  <= pend_r.bytes;
          out_result_r.is_sending  <= 1'b0;
          out_result_r.last        <= 1'b0;
        end
        pend_r      <= rd_slot_r;
        have_pend_r <= 1'b1;
      end

      // Step to the next slot in use, or close the walk.
      if (advance) begin
        idx_r   <= idx_inc;
        state_r <= (idx_inc == slots_used_r) ? ST_DONE : ST_FETCH;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // The slot walk only runs while sending.
  a_busy_sending: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (mode_r == MODE_SENDING))
    else $error("slot walk active outside sending mode");

  // The walk index stays within the slots in use.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_EVAL || state_r == ST_MOD) |->
      (idx_r < slots_used_r))
    else $error("walk index beyond slots in use");

  // A result that is not the last one is followed by more work on the same request.
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.last) |-> busy)
    else $error("non-final result with no request in progress");

  // Each subtraction step lowers the running sum.
  a_mod_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD && sub_ge) |=> (sum_r < $past(sum_r)))
    else $error("modulo step did not reduce the sum");

  // State reports are always single results.
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.result_kind == RES_REPORT) |->
      (out_result.last && !busy))
    else $error("state report not final or issued during a walk");

endmodule
